// ----- rtl/pcf_pkg.sv -----
// Shared constants for the power-of-two coefficient FIR filter.
// No dependencies; imported by the filter top level.
`timescale 1ns / 1ps

package pcf_pkg;

    localparam int TAPS         = 256;
    localparam int COEFF_DIGITS = 16;

    // Tap address and fill counter widths.
    localparam int TAP_AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FILL_W  = $clog2(TAPS + 1);

    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int COEF_W   = 17;   // signed sum of digits, |c| < 2^16
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int OUT_W    = 40;

    // Digits 2^-1 .. 2^-COEFF_DIGITS live in the top COEFF_DIGITS presence bits.
    localparam logic [15:0] DIGIT_MASK =
        16'(((1 << COEFF_DIGITS) - 1) << (16 - COEFF_DIGITS));

    typedef logic [TAP_AW-1:0]         tap_addr_t;
    typedef logic [FILL_W-1:0]         fill_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [OUT_W-1:0]   acc_t;

endpackage

// ----- rtl/pcf_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/pot_coefficient_fir_filter.sv -----
// Top level of the power-of-two coefficient FIR filter.
// Depends on pcf_pkg (constants, types) and pcf_ram (coefficient and sample stores).
`timescale 1ns / 1ps

// How to use:
// - Input channel (in_valid / in_stall): each beat is either a coefficient load
//   (action = 0: coeff_word goes to tap coeff_index; indexes not below TAPS are
//   dropped) or a sample (action = 1: sample enters the delay line and one
//   filtered beat follows). Load every tap used before filtering.
// - Output channel (out_valid / out_stall): one filtered beat per sample,
//   held stable while out_stall is high.
// - Coefficient load: taken whenever the block is idle; the next beat can follow right away.
// - Sample: one shared 16x17 multiplier and 40-bit accumulator walk the taps,
//   one tap per clock, through a four-deep pipeline (RAM read, digit decode,
//   multiply, accumulate). The result is registered once the walk has drained
//   through the pipeline, and in_stall stays high until then, so a new sample
//   is not taken before the last one is through. The tap walk sets the pace.
// - A result waiting on out_stall does not block new beats: the next sample
//   is taken and only its final hand-off waits for the output register.
// - Reset: delay line reads as zero through a fill count (no clearing pass),
//   write pointer goes to zero, coefficient store keeps whatever it held.
//   The block is ready as soon as reset is released.

module pot_coefficient_fir_filter
    import pcf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [INDEX_W-1:0]         coeff_index,
    input  logic [WORD_W-1:0]          coeff_word,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_W-1:0]    filtered
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam tap_addr_t LAST_TAP = TAP_AW'(TAPS - 1);
    localparam fill_t     FULL     = FILL_W'(TAPS);

    logic [1:0] state_reg, state_next;
    tap_addr_t  k_reg, k_next;        // tap being issued
    tap_addr_t  rp_reg, rp_next;      // delay line position of tap k
    tap_addr_t  wp_reg, wp_next;      // next sample slot
    fill_t      fill_reg, fill_next;  // samples written, saturates at TAPS

    // pipeline valids and tap-in-range flag
    logic v1_reg, v2_reg, v3_reg;
    logic ok1_reg;

    coef_t                       c_reg;
    logic signed [SAMPLE_W-1:0]  x_reg;
    prod_t                       prod_reg;
    acc_t                        acc_reg, acc_next;

    logic                        out_valid_reg, out_valid_next;
    acc_t                        filtered_reg;

    logic                        accept;
    logic                        take_sample;
    logic                        coef_we;
    logic                        out_free;
    logic                        issue;

    logic [WORD_W-1:0]           coef_rdata;
    logic [SAMPLE_W-1:0]         delay_rdata;
    logic [15:0]                 pres, neg_bits;
    coef_t                       c_val;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    assign accept      = in_valid && !in_stall;
    assign take_sample = accept && action;
    assign coef_we     = accept && !action && ({24'd0, coeff_index} < 32'(TAPS));
    assign out_free    = !out_valid_reg || !out_stall;
    assign issue       = (state_reg == ST_RUN);

    pcf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (TAP_AW'(coeff_index)),
        .wdata (coeff_word),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    // Sample written at accept; the first tap read issues in the cycle after.
    pcf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (take_sample),
        .waddr (wp_reg),
        .wdata (sample),
        .raddr (rp_reg),
        .rdata (delay_rdata)
    );

    // Digit decode: c = sum of +/- 2^(16-j) over present digits.
    always_comb
    begin
        pres     = coef_rdata[15:0] & DIGIT_MASK;
        neg_bits = pres & coef_rdata[31:16];
        c_val    = coef_t'({1'b0, pres & ~neg_bits}) - coef_t'({1'b0, neg_bits});
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (v3_reg)
        begin
            acc_next = acc_reg + OUT_W'(prod_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take_sample)
                begin
                    state_next = ST_RUN;
                    k_next     = '0;
                    rp_next    = wp_reg;
                    wp_next    = (wp_reg == LAST_TAP) ? '0 : wp_reg + 1'b1;
                    fill_next  = (fill_reg == FULL) ? fill_reg : fill_reg + 1'b1;
                    acc_next   = '0;
                end
            end
            ST_RUN:
            begin
                k_next  = k_reg + 1'b1;
                rp_next = (rp_reg == '0) ? LAST_TAP : rp_reg - 1'b1;
                if (k_reg == LAST_TAP)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath, no reset needed.
    always_ff @(posedge clk)
    begin
        ok1_reg  <= (FILL_W'(rp_reg) < fill_reg);
        c_reg    <= c_val;
        x_reg    <= ok1_reg ? signed'(delay_rdata) : '0;
        prod_reg <= x_reg * c_reg;
        acc_reg  <= acc_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            filtered_reg <= acc_reg;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for pot_coefficient_fir_filter.
// Needs pcf_pkg and the filter RTL. It predicts every filtered beat and checks it
// against the block's output.
`timescale 1ns / 1ps

module tb_top;

    import pcf_pkg::*;

    // Beat kinds on the input channel.
    typedef enum logic {ACT_LOAD = 1'b0, ACT_FILTER = 1'b1} action_t;

    typedef struct {
        action_t                     act;
        logic [INDEX_W-1:0]          idx;
        logic [WORD_W-1:0]           word;
        logic signed [SAMPLE_W-1:0]  smp;
    } beat_t;

    localparam int RANDOM_BEATS  = 280;
    localparam int DRAIN_CYCLES  = TAPS + 40;   // one full tap walk plus margin
    localparam int HOLD_CYCLES   = 1500;        // long output hold-off, several samples
    localparam int HOLD_AFTER    = 60;          // results seen before the hold-off starts

    // DUT ports. Every input has a known value from time zero.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       action = 1'b0;
    logic [INDEX_W-1:0]         coeff_index = '0;
    logic [WORD_W-1:0]          coeff_word = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [OUT_W-1:0]    filtered;

    // Stimulus and scoreboard.
    beat_t pending_beats[$];
    acc_t  expected_filtered[$];
    beat_t beat_on_bus;
    int    fail_count = 0;
    int    results_seen = 0;

    // Local copy of filter state: coefficient words, sample history, next slot.
    logic [WORD_W-1:0]          coeff_copy [TAPS];
    logic signed [SAMPLE_W-1:0] history [TAPS] = '{default: '0};
    int                         head = 0;

    // Idle pacing for both sides.
    int send_gap = 0;
    int send_calm = 0;
    int stall_left = 0;
    int stall_calm = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;

    pot_coefficient_fir_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .coeff_index (coeff_index),
        .coeff_word  (coeff_word),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .filtered    (filtered)
    );

    always #2 clk = ~clk;

    // Mostly short gaps, a few long ones, and now and then a calm stretch
    // of back-to-back beats with no gaps at all.
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 4)
        begin
            calm = $urandom_range(20, 50);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coefficient words: corner patterns now and then, otherwise any 32 bits.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;    // every digit, all negative
            2: return 32'h0000_FFFF;    // every digit, all positive
            3: return 32'hFFFF_0000;    // signs set but no digit present
            4: return 32'h8000_8000;    // -1/2 only
            5: return 32'h0000_0001;    // smallest digit only
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Unused fields of a beat still carry random bits.
    task automatic add_load(input int unsigned tap, input logic [WORD_W-1:0] w);
        beat_t b;
        b.act  = ACT_LOAD;
        b.idx  = INDEX_W'(tap);
        b.word = w;
        b.smp  = SAMPLE_W'($urandom);
        pending_beats.push_back(b);
    endtask

    task automatic add_sample(input logic signed [SAMPLE_W-1:0] s);
        beat_t b;
        b.act  = ACT_FILTER;
        b.idx  = INDEX_W'($urandom);
        b.word = $urandom;
        b.smp  = s;
        pending_beats.push_back(b);
    endtask

    // Filter prediction. A load updates the coefficient copy; a sample enters
    // the history and yields one 40-bit sum over all taps. Each present digit j
    // adds or subtracts (x << 16) >>> j, so every term is exact.
    task automatic predict_filtered(input beat_t b);
        logic signed [63:0] scaled;
        logic signed [63:0] term;
        logic [63:0]        total;
        logic [WORD_W-1:0]  w;
        int                 pos;
        if (b.act == ACT_LOAD)
        begin
            if (int'(b.idx) < TAPS)
                coeff_copy[b.idx] = b.word;
        end
        else
        begin
            history[head] = b.smp;
            total = '0;
            for (int k = 0; k < TAPS; k++)
            begin
                pos    = (head + TAPS - k) % TAPS;
                scaled = history[pos];
                scaled = scaled <<< 16;
                w      = coeff_copy[k];
                for (int j = 1; j <= COEFF_DIGITS; j++)
                begin
                    if (w[16 - j])
                    begin
                        term = scaled >>> j;
                        if (w[32 - j])
                            total = total - term;
                        else
                            total = total + term;
                    end
                end
            end
            head = (head + 1) % TAPS;
            expected_filtered.push_back(total[OUT_W-1:0]);
        end
    endtask

    // Input driver. A beat stays on the bus until accepted; the next one goes
    // out at the same edge unless an idle gap is due.
    always @(posedge clk)
    begin
        beat_t nb;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_filtered(beat_on_bus);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    nb          = pending_beats.pop_front();
                    beat_on_bus = nb;
                    action      <= nb.act;
                    coeff_index <= nb.idx;
                    coeff_word  <= nb.word;
                    sample      <= nb.smp;
                    in_valid    <= 1'b1;
                    send_gap    = pick_gap(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall. Random short/long stalls, plus a single long hold-off once
    // results are flowing: the block then parks one result, takes the next
    // sample, and has to stall its input while the sender keeps offering.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!pressure_done && results_seen >= HOLD_AFTER)
            begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES;
                out_stall     <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 9) < 3)
                    stall_left = pick_gap(stall_calm);
            end
        end
    end

    // Output monitor: every accepted beat against the oldest prediction.
    always @(posedge clk)
    begin
        acc_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_filtered.size() == 0)
            begin
                $error("filtered: unexpected beat, actual %0d", filtered);
                fail_count++;
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (filtered !== want)
                begin
                    $error("filtered: expected %0d, actual %0d", want, filtered);
                    fail_count++;
                end
            end
        end
    end

    // Hard stop for a hung run.
    initial
    begin
        #3_000_000;
        $display("pot_coefficient_fir_filter test failed");
        $finish;
    end

    initial
    begin
        // Every tap gets a word before the first sample: a sample reads all of
        // them. The first few taps get corner patterns.
        for (int k = 0; k < TAPS; k++)
        begin
            case (k)
                0:       add_load(k, 32'h0000_FFFF);
                1:       add_load(k, 32'hFFFF_FFFF);
                2:       add_load(k, 32'h8000_8000);
                3:       add_load(k, 32'h0000_0001);
                4:       add_load(k, 32'hFFFF_0000);
                TAPS-1:  add_load(k, 32'h8000_FFFF);
                default: add_load(k, $urandom);
            endcase
        end

        // Directed: sample extremes into a mostly empty delay line, then
        // reloads of the newest and oldest taps between samples.
        add_sample(16'sh7FFF);
        add_sample(16'sh8000);
        add_sample(16'sh0000);
        add_sample(16'shFFFF);
        add_sample(16'sh0001);
        add_sample(16'sh8000);
        add_load(0, 32'h0000_0000);
        add_sample(16'sh7FFF);
        add_load(0, 32'hFFFF_FFFF);
        add_load(TAPS-1, 32'h0000_FFFF);
        add_sample(16'sh8000);
        add_load(0, 32'hFFFF_0000);
        add_sample(16'sh5555);
        add_load(0, 32'h0000_FFFF);
        add_load(1, 32'h0000_FFFF);
        add_sample(16'shAAAA);
        add_sample(16'sh8000);
        add_sample(16'sh8000);

        // Random: mostly samples, some coefficient rewrites, and occasional runs
        // of one extreme sample to build large sums.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_load($urandom_range(0, TAPS - 1), pick_word());
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                logic signed [SAMPLE_W-1:0] s;
                s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                for (int r = 0; r < 16; r++)
                    add_sample(s);
                n += 15;
            end
            else
            begin
                add_sample(pick_sample());
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so the driver's updates at the rising
        // edge are settled.
        while (pending_beats.size() != 0 || in_valid || expected_filtered.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_filtered.size() != 0)
        begin
            $error("filtered: %0d beats never arrived", expected_filtered.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("pot_coefficient_fir_filter test passed");
        else
            $display("pot_coefficient_fir_filter test failed");
        $finish;
    end

endmodule
